// ----- design/tapc_pkg.sv -----
package tapc_pkg;

  localparam int MAX_NODES     = 1024;
  localparam int ALPHABET_SIZE = 26;
  localparam int MAX_WORD_LEN  = 256;

  localparam int ACTION_W = 3;
  localparam int LETTER_W = 5;
  localparam int PRESS_W  = 9;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = ((ACTION_W + LETTER_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PRESS_W + STATUS_W + 7) / 8) * 8;

  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int USED_W     = $clog2(MAX_NODES + 1);
  localparam int ALPHA_W    = $clog2(ALPHABET_SIZE);
  localparam int CNT_W      = $clog2(ALPHABET_SIZE + 1);
  localparam int POS_W      = $clog2(MAX_WORD_LEN + 1);
  localparam int LINK_DEPTH = MAX_NODES * ALPHABET_SIZE;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);
  localparam int PARENT_W   = NODE_W + ALPHA_W;
  localparam int INFO_W     = CNT_W + 1;

  localparam logic [PRESS_W-1:0] TALLY_MAX = '1;

  localparam logic [ACTION_W-1:0] ACT_INS_LETTER = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_END    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_QRY_LETTER = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_QRY_END    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic capture;
    logic sweep;
    logic decide;
    logic zero;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic needs_zero;
  } sts_t;

endpackage

// ----- design/tapc_ram.sv -----
module tapc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tapc_ctrl.sv -----
module tapc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  input  tapc_pkg::sts_t sts_i,
  output tapc_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CHECK,
    ST_DECIDE,
    ST_ZERO
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_INIT:   cmd_o.sweep   = 1'b1;
      ST_IDLE:   cmd_o.capture = s_tvalid_i && ready_q;
      ST_DECIDE: cmd_o.decide  = out_free;
      ST_ZERO:   cmd_o.zero    = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.decide) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT: begin
          if (sts_i.sweep_last) begin
            state_q <= ST_ZERO;
          end
        end
        ST_IDLE: begin
          if (cmd_o.capture) begin
            state_q <= ST_CHECK;
            ready_q <= 1'b0;
          end
        end
        ST_CHECK: begin
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (cmd_o.decide) begin
            if (sts_i.needs_zero) begin
              state_q <= ST_ZERO;
            end else begin
              state_q <= ST_IDLE;
              ready_q <= 1'b1;
            end
          end
        end
        ST_ZERO: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
        default: begin
          state_q <= ST_INIT;
          ready_q <= 1'b0;
        end
      endcase
    end
  end

  assign s_tready_o = ready_q;
  assign m_tvalid_o = out_valid_q;

  a_capture_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> !ready_q && state_q == ST_CHECK)
    else $error("input accepted while an item is in progress");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DECIDE && !out_free |=> state_q == ST_DECIDE && out_valid_q)
    else $error("result committed while output slot is occupied");

endmodule

// ----- design/tapc_dp.sv -----
module tapc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tapc_pkg::cmd_t                      cmd_i,
  output tapc_pkg::sts_t                      sts_o,
  input  logic [tapc_pkg::IN_TDATA_W-1:0]     in_tdata_i,
  output logic [tapc_pkg::OUT_TDATA_W-1:0]    out_tdata_o
);

  logic [tapc_pkg::ACTION_W-1:0] act_q;
  logic [tapc_pkg::LETTER_W-1:0] let_q;
  logic [tapc_pkg::LETTER_W-1:0] in_let;
  logic [tapc_pkg::LETTER_W-1:0] let_sel;
  logic [tapc_pkg::ALPHA_W-1:0]  let_idx;
  logic [tapc_pkg::ALPHA_W-1:0]  let_q_idx;
  logic                          let_ok;

  logic [tapc_pkg::NODE_W-1:0]   cursor_q, cursor_d;
  logic [tapc_pkg::USED_W-1:0]   used_q, used_d;
  logic [tapc_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [tapc_pkg::PRESS_W-1:0]  tally_q, tally_d;
  logic                          err_q, err_d;
  logic [tapc_pkg::NODE_W-1:0]   zero_idx_q, zero_idx_d;
  logic [tapc_pkg::LINK_AW-1:0]  sweep_q;
  logic [tapc_pkg::PRESS_W-1:0]  pres_q, pres_d;
  logic [tapc_pkg::STATUS_W-1:0] stat_q, stat_d;

  logic [tapc_pkg::LINK_AW-1:0]  link_addr;
  logic [tapc_pkg::NODE_W-1:0]   link_rd;
  logic                          link_we;
  logic [tapc_pkg::PARENT_W-1:0] par_rd;
  logic                          par_we;
  logic [tapc_pkg::INFO_W-1:0]   info_rd;
  logic [tapc_pkg::INFO_W-1:0]   info_wd;
  logic                          info_we;
  logic [tapc_pkg::CNT_W-1:0]    info_cnt;
  logic                          info_mark;
  logic                          hit;
  logic                          alloc;
  logic                          end_word;

  assign in_let    = in_tdata_i[tapc_pkg::ACTION_W +: tapc_pkg::LETTER_W];
  assign let_sel   = cmd_i.capture ? in_let : let_q;
  assign let_idx   = (32'(let_sel) < 32'(tapc_pkg::ALPHABET_SIZE)) ?
                     tapc_pkg::ALPHA_W'(let_sel) : '0;
  assign let_ok    = 32'(let_q) < 32'(tapc_pkg::ALPHABET_SIZE);
  assign let_q_idx = tapc_pkg::ALPHA_W'(let_q);

  assign link_addr = tapc_pkg::LINK_AW'(cursor_q) *
                     tapc_pkg::LINK_AW'(tapc_pkg::ALPHABET_SIZE) +
                     tapc_pkg::LINK_AW'(let_idx);

  assign info_cnt  = info_rd[tapc_pkg::INFO_W-1:1];
  assign info_mark = info_rd[0];

  // A link counts only if its target node is live and records this slot as its parent.
  assign hit = (link_rd != '0) && (tapc_pkg::USED_W'(link_rd) < used_q) &&
               (par_rd == {cursor_q, let_q_idx});

  tapc_ram #(
    .WIDTH (tapc_pkg::NODE_W),
    .DEPTH (tapc_pkg::LINK_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sweep || (cmd_i.decide && link_we)),
    .waddr_i (cmd_i.sweep ? sweep_q : link_addr),
    .wdata_i (cmd_i.sweep ? '0 : used_q[tapc_pkg::NODE_W-1:0]),
    .raddr_i (link_addr),
    .rdata_o (link_rd)
  );

  tapc_ram #(
    .WIDTH (tapc_pkg::PARENT_W),
    .DEPTH (tapc_pkg::MAX_NODES)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.decide && par_we),
    .waddr_i (used_q[tapc_pkg::NODE_W-1:0]),
    .wdata_i ({cursor_q, let_q_idx}),
    .raddr_i (link_rd),
    .rdata_o (par_rd)
  );

  tapc_ram #(
    .WIDTH (tapc_pkg::INFO_W),
    .DEPTH (tapc_pkg::MAX_NODES)
  ) u_info_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.zero || (cmd_i.decide && info_we)),
    .waddr_i (cmd_i.zero ? zero_idx_q : cursor_q),
    .wdata_i (cmd_i.zero ? '0 : info_wd),
    .raddr_i (cursor_q),
    .rdata_o (info_rd)
  );

  always_comb begin
    cursor_d   = cursor_q;
    used_d     = used_q;
    pos_d      = pos_q;
    tally_d    = tally_q;
    err_d      = err_q;
    zero_idx_d = zero_idx_q;
    pres_d     = '0;
    stat_d     = tapc_pkg::ST_OK;
    link_we    = 1'b0;
    par_we     = 1'b0;
    info_we    = 1'b0;
    info_wd    = info_rd;
    alloc      = 1'b0;
    end_word   = 1'b0;
    case (act_q)
      tapc_pkg::ACT_INS_LETTER: begin
        if (err_q) begin
          stat_d = tapc_pkg::ST_FULL;
        end else if (let_ok && pos_q < tapc_pkg::POS_W'(tapc_pkg::MAX_WORD_LEN)) begin
          if (hit) begin
            cursor_d = link_rd;
            pos_d    = pos_q + tapc_pkg::POS_W'(1);
          end else if (used_q >= tapc_pkg::USED_W'(tapc_pkg::MAX_NODES)) begin
            err_d  = 1'b1;
            stat_d = tapc_pkg::ST_FULL;
          end else begin
            alloc      = 1'b1;
            link_we    = 1'b1;
            par_we     = 1'b1;
            info_we    = 1'b1;
            info_wd    = {info_cnt + tapc_pkg::CNT_W'(1), info_mark};
            cursor_d   = used_q[tapc_pkg::NODE_W-1:0];
            zero_idx_d = used_q[tapc_pkg::NODE_W-1:0];
            used_d     = used_q + tapc_pkg::USED_W'(1);
            pos_d      = pos_q + tapc_pkg::POS_W'(1);
          end
        end
      end
      tapc_pkg::ACT_INS_END: begin
        if (err_q) begin
          stat_d = tapc_pkg::ST_FULL;
        end else begin
          info_we = 1'b1;
          info_wd = {info_cnt, 1'b1};
        end
        end_word = 1'b1;
      end
      tapc_pkg::ACT_QRY_LETTER: begin
        if (err_q) begin
          stat_d = tapc_pkg::ST_MISS;
        end else if (pos_q < tapc_pkg::POS_W'(tapc_pkg::MAX_WORD_LEN)) begin
          if (!let_ok) begin
            err_d  = 1'b1;
            stat_d = tapc_pkg::ST_MISS;
          end else begin
            if (pos_q == '0) begin
              tally_d = tapc_pkg::PRESS_W'(1);
            end else if ((info_cnt > tapc_pkg::CNT_W'(1) || info_mark) &&
                         tally_q != tapc_pkg::TALLY_MAX) begin
              tally_d = tally_q + tapc_pkg::PRESS_W'(1);
            end
            if (hit) begin
              cursor_d = link_rd;
              pos_d    = pos_q + tapc_pkg::POS_W'(1);
            end else begin
              err_d  = 1'b1;
              stat_d = tapc_pkg::ST_MISS;
            end
          end
        end
      end
      tapc_pkg::ACT_QRY_END: begin
        if (err_q) begin
          stat_d = tapc_pkg::ST_MISS;
        end else begin
          pres_d = (pos_q == '0) ? tapc_pkg::PRESS_W'(1) : tally_q;
        end
        end_word = 1'b1;
      end
      tapc_pkg::ACT_CLEAR: begin
        used_d     = tapc_pkg::USED_W'(1);
        zero_idx_d = '0;
        end_word   = 1'b1;
      end
      default: begin
        stat_d = tapc_pkg::ST_OK;
      end
    endcase
    if (end_word) begin
      cursor_d = '0;
      pos_d    = '0;
      tally_d  = '0;
      err_d    = 1'b0;
    end
  end

  assign sts_o.needs_zero = alloc || (act_q == tapc_pkg::ACT_CLEAR);
  assign sts_o.sweep_last = sweep_q == tapc_pkg::LINK_AW'(tapc_pkg::LINK_DEPTH - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= in_tdata_i[tapc_pkg::ACTION_W-1:0];
      let_q <= in_let;
    end
    if (cmd_i.decide) begin
      pres_q <= pres_d;
      stat_q <= stat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q   <= '0;
      used_q     <= tapc_pkg::USED_W'(1);
      pos_q      <= '0;
      tally_q    <= '0;
      err_q      <= 1'b0;
      zero_idx_q <= '0;
      sweep_q    <= '0;
    end else begin
      if (cmd_i.sweep) begin
        sweep_q <= sweep_q + tapc_pkg::LINK_AW'(1);
      end
      if (cmd_i.decide) begin
        cursor_q   <= cursor_d;
        used_q     <= used_d;
        pos_q      <= pos_d;
        tally_q    <= tally_d;
        err_q      <= err_d;
        zero_idx_q <= zero_idx_d;
      end
    end
  end

  assign out_tdata_o = tapc_pkg::OUT_TDATA_W'({stat_q, pres_q});

  a_cursor_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tapc_pkg::USED_W'(cursor_q) < used_q)
    else $error("cursor points past the allocated nodes");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q != '0 && used_q <= tapc_pkg::USED_W'(tapc_pkg::MAX_NODES) &&
    pos_q <= tapc_pkg::POS_W'(tapc_pkg::MAX_WORD_LEN))
    else $error("node count or letter position out of range");

  a_alloc_bumps_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide && alloc |=> used_q == $past(used_q) + tapc_pkg::USED_W'(1))
    else $error("node allocation did not advance the pool");

endmodule

// ----- design/trie_autocomplete_press_count_core.sv -----
// Keystroke counter over a letter trie held in on-chip RAM.
// Input channel s_axis: one transaction per action (insert letter, insert end,
// query letter, query end, clear). Output channel m_axis: exactly one result
// transaction per input transaction, in order, carrying presses and status.
// The block works on one action at a time. The child-link RAM is read at the
// accepting edge, the parent record of the found link is read in the check
// state that follows, and the result register is loaded in the decide state
// once the output register is free. An insert that allocates a node and a
// clear then pass through a zero state that zeroes a node info entry.
// Because of the chain of registered RAM reads (child link, then its parent
// record), a new action is accepted only once the previous one has finished.
// A result waiting in the output register is held while m_axis_tready is low;
// the next action is processed but its result is committed only once the
// output register is free.
// After reset the child-link RAM is swept to zero, one entry per cycle, over
// all MAX_NODES * ALPHABET_SIZE entries (26624), and the root's node info entry
// is then zeroed; s_axis_tready stays low meanwhile. A clear action needs no
// sweep of the child-link RAM; stale links fail the live and parent checks.
module trie_autocomplete_press_count_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: action[2:0], letter[7:3].
  input  logic [tapc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0: presses[8:0], status[10:9], zero padding above.
  output logic [tapc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  tapc_pkg::cmd_t cmd;
  tapc_pkg::sts_t sts;

  tapc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tapc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_tdata_i  (s_axis_tdata),
    .out_tdata_o (m_axis_tdata)
  );

endmodule
